FILE: src/operand_stack_engine_macros.svh
// ----------------------------------------------------------------------------
// operand_stack_engine assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef OPERAND_STACK_ENGINE_MACROS_SVH
`define OPERAND_STACK_ENGINE_MACROS_SVH

// plain property, sampled on clk, off while arst_n is low
`define OSE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define OSE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OSE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/ose_pkg.sv
// ----------------------------------------------------------------------------
// ose_pkg
// Command codes, status codes and shared types of the operand stack engine.
// ----------------------------------------------------------------------------
package ose_pkg;

	localparam int CMD_W = 3;
	localparam int ST_W  = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_NOP  = 3'd0,
		CMD_PUSH = 3'd1,
		CMD_POP  = 3'd2,
		CMD_SWAP = 3'd3,
		CMD_ADD  = 3'd4,
		CMD_LIST = 3'd5
	} cmd_t;

	typedef logic [ST_W-1:0] status_t;

	localparam status_t ST_OK         = 3'd0;
	localparam status_t ST_POP_EMPTY  = 3'd1;
	localparam status_t ST_SWAP_SHORT = 3'd2;
	localparam status_t ST_ADD_SHORT  = 3'd3;
	localparam status_t ST_PUSH_FULL  = 3'd4;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_OP,
		BS_LIST
	} back_state_t;

	// front -> back command handshake (value travels beside it)
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} op_ctl_t;

endpackage

FILE: src/ose_front.sv
// ----------------------------------------------------------------------------
// ose_front
// Accepts input words, decodes the command and queues them (two deep).
// ----------------------------------------------------------------------------
module ose_front import ose_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [CMD_W-1:0]      in_cmd,
	input  logic [DATA_WIDTH-1:0] in_value,
	output op_ctl_t               op,
	output logic [DATA_WIDTH-1:0] op_value,
	input  logic                  op_ready
);

	cmd_t                  cmd_q  [2];
	logic [DATA_WIDTH-1:0] val_q  [2];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            fill_q;
	cmd_t                  cmd_dec;
	logic                  push;
	logic                  pop;

	// unused codes fall back to nop
	always_comb begin
		case (in_cmd)
			CMD_PUSH: cmd_dec = CMD_PUSH;
			CMD_POP:  cmd_dec = CMD_POP;
			CMD_SWAP: cmd_dec = CMD_SWAP;
			CMD_ADD:  cmd_dec = CMD_ADD;
			CMD_LIST: cmd_dec = CMD_LIST;
			default:  cmd_dec = CMD_NOP;
		endcase
	end

	assign in_ready = (fill_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign pop      = op.valid && op_ready;

	assign op.valid = (fill_q != 2'd0);
	assign op.cmd   = cmd_q[rd_ptr_q];
	assign op_value = val_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wr_ptr_q] <= cmd_dec;
			val_q[wr_ptr_q] <= in_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

FILE: src/ose_back.sv
// ----------------------------------------------------------------------------
// ose_back
// Executes queued commands on the stack and drives the result register.
// ----------------------------------------------------------------------------
`include "operand_stack_engine_macros.svh"

module ose_back import ose_pkg::*; #(
	parameter int STACK_DEPTH = 64,
	parameter int DATA_WIDTH  = 32,
	localparam int CNT_W      = $clog2(STACK_DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  op_ctl_t               op,
	input  logic [DATA_WIDTH-1:0] op_value,
	output logic                  op_ready,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic [DATA_WIDTH-1:0] res_value,
	output logic                  res_has,
	output status_t               res_status,
	output logic                  res_last,
	output logic [CNT_W-1:0]      res_count
);

	localparam int AW    = $clog2(STACK_DEPTH);
	localparam int MEM_D = STACK_DEPTH - 1;

	// top entry lives in top_q; entries below it live in stack_mem
	logic [DATA_WIDTH-1:0] stack_mem [MEM_D];

	back_state_t           state_q, state_n;
	logic [CNT_W-1:0]      count_q, count_n;
	logic [DATA_WIDTH-1:0] top_q, top_n;
	cmd_t                  op_q, op_n;
	logic [AW-1:0]         idx_q, idx_n;
	logic [DATA_WIDTH-1:0] rdata_q;

	logic                  rd_en, wr_en;
	logic [AW-1:0]         rd_addr, wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;

	logic                  emit;
	logic [DATA_WIDTH-1:0] e_val;
	logic                  e_has;
	status_t               e_st;
	logic                  e_last;
	logic [CNT_W-1:0]      e_cnt;

	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] out_val_q;
	logic                  out_has_q;
	status_t               out_st_q;
	logic                  out_last_q;
	logic [CNT_W-1:0]      out_cnt_q;

	logic                  slot_free;
	logic [CNT_W-1:0]      cnt_m1, cnt_m2;
	logic                  two_plus, empty, full;
	logic [DATA_WIDTH-1:0] cur_val;
	logic [DATA_WIDTH-1:0] sum;

	assign slot_free = !out_valid_q || res_ready;
	assign cnt_m1    = count_q - CNT_W'(1);
	assign cnt_m2    = count_q - CNT_W'(2);
	assign two_plus  = (count_q >= CNT_W'(2));
	assign empty     = (count_q == '0);
	assign full      = (count_q == CNT_W'(STACK_DEPTH));
	assign cur_val   = empty ? '0 : top_q;
	assign sum       = rdata_q + top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
			count_q <= '0;
			op_q    <= CMD_NOP;
			idx_q   <= '0;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
			op_q    <= op_n;
			idx_q   <= idx_n;
		end
	end

	// top value is payload; only meaningful while count_q != 0
	always_ff @(posedge clk) begin
		top_q <= top_n;
	end

	always_ff @(posedge clk) begin
		if (wr_en) stack_mem[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= stack_mem[rd_addr];
	end

	always_comb begin
		state_n  = state_q;
		count_n  = count_q;
		top_n    = top_q;
		op_n     = op_q;
		idx_n    = idx_q;
		op_ready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = cnt_m2[AW-1:0];
		wr_en    = 1'b0;
		wr_addr  = cnt_m2[AW-1:0];
		wr_data  = top_q;
		emit     = 1'b0;
		e_val    = cur_val;
		e_has    = !empty;
		e_st     = ST_OK;
		e_last   = 1'b1;
		e_cnt    = count_q;

		case (state_q)
			BS_IDLE: begin
				if (op.valid && slot_free) begin
					op_ready = 1'b1;
					case (op.cmd)
						CMD_PUSH: begin
							emit = 1'b1;
							if (full) begin
								e_st = ST_PUSH_FULL;
							end else begin
								// old top sinks into memory
								wr_en   = !empty;
								wr_addr = cnt_m1[AW-1:0];
								top_n   = op_value;
								count_n = count_q + CNT_W'(1);
								e_val   = op_value;
								e_has   = 1'b1;
								e_cnt   = count_q + CNT_W'(1);
							end
						end
						CMD_POP: begin
							if (empty) begin
								emit = 1'b1;
								e_st = ST_POP_EMPTY;
							end else if (!two_plus) begin
								emit    = 1'b1;
								count_n = '0;
								e_val   = '0;
								e_has   = 1'b0;
								e_cnt   = '0;
							end else begin
								rd_en   = 1'b1;
								op_n    = CMD_POP;
								state_n = BS_OP;
							end
						end
						CMD_SWAP, CMD_ADD: begin
							if (!two_plus) begin
								emit = 1'b1;
								e_st = (op.cmd == CMD_SWAP) ? ST_SWAP_SHORT : ST_ADD_SHORT;
							end else begin
								rd_en   = 1'b1;
								op_n    = op.cmd;
								state_n = BS_OP;
							end
						end
						CMD_LIST: begin
							emit   = 1'b1;
							e_last = !two_plus;
							if (two_plus) begin
								rd_en   = 1'b1;
								idx_n   = cnt_m2[AW-1:0];
								state_n = BS_LIST;
							end
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			BS_OP: begin
				if (slot_free) begin
					emit    = 1'b1;
					e_has   = 1'b1;
					state_n = BS_IDLE;
					case (op_q)
						CMD_POP: begin
							top_n   = rdata_q;
							count_n = cnt_m1;
							e_val   = rdata_q;
							e_cnt   = cnt_m1;
						end
						CMD_SWAP: begin
							wr_en = 1'b1;
							top_n = rdata_q;
							e_val = rdata_q;
						end
						CMD_ADD: begin
							top_n   = sum;
							count_n = cnt_m1;
							e_val   = sum;
							e_cnt   = cnt_m1;
						end
						default: begin
							e_val = cur_val;
						end
					endcase
				end
			end
			BS_LIST: begin
				if (slot_free) begin
					emit   = 1'b1;
					e_val  = rdata_q;
					e_has  = 1'b1;
					e_last = (idx_q == '0);
					if (idx_q == '0) begin
						state_n = BS_IDLE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = idx_q - AW'(1);
						idx_n   = idx_q - AW'(1);
					end
				end
			end
			default: begin
				state_n = BS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_val_q  <= e_val;
			out_has_q  <= e_has;
			out_st_q   <= e_st;
			out_last_q <= e_last;
			out_cnt_q  <= e_cnt;
		end
	end

	assign res_valid  = out_valid_q;
	assign res_value  = out_val_q;
	assign res_has    = out_has_q;
	assign res_status = out_st_q;
	assign res_last   = out_last_q;
	assign res_count  = out_cnt_q;

	`OSE_ASSERT(a_count_bound, count_q <= CNT_W'(STACK_DEPTH), "entry count above depth")
	`OSE_ASSERT_IMP(a_busy_two, state_q != BS_IDLE, two_plus, "multi-cycle op with < 2 entries")
	`OSE_ASSERT_IMP(a_empty_zero, out_valid_q && !out_has_q,
		out_cnt_q == '0 || out_st_q != ST_OK, "empty result with entries held")
	`OSE_ASSERT_NXT(a_list_end, state_q == BS_LIST && emit && idx_q == '0,
		state_q == BS_IDLE, "list did not end after bottom entry")

endmodule

FILE: src/operand_stack_engine.sv
// ----------------------------------------------------------------------------
// operand_stack_engine
// Bounded LIFO operand stack: push, pop, swap, add and list commands.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream s_*: one word per command. s_tdata holds command (3 bits)
//    and operand_value; operand_value matters for push only.
//  - Output stream m_*: one word per command, except list, which gives one
//    word per entry from top to bottom (one empty word if nothing is held).
//    m_tlast marks the final word of a command.
//  - Commands pass a two-deep queue into the executor, so input is taken
//    while a result waits on m_tready.
//  - Timing: nop, push, pop of the last entry, list of under two entries and
//    failing commands finish in the executor's idle state; pop, swap and add
//    on two or more entries also pass an op state (registered read of the
//    entry under the top); list gives one entry per cycle unless m_tready
//    is low. m_tvalid follows acceptance via queue, then result register.
//  - When m_tready is low the result register holds and the executor waits;
//    the queue keeps accepting until it holds two commands.
//  - Reset (arst_n low) empties the stack and the queue; memory contents
//    are not cleared, as only written entries are ever read.
//  - Faults (pop empty, short swap/add, push full) leave the stack as is
//    and report status in m_tuser.
// ----------------------------------------------------------------------------
module operand_stack_engine import ose_pkg::*; #(
	parameter int STACK_DEPTH = 64,
	parameter int DATA_WIDTH  = 32,
	localparam int CNT_W      = $clog2(STACK_DEPTH + 1),
	localparam int IN_W       = ((CMD_W + DATA_WIDTH + 7) / 8) * 8,
	localparam int OUT_W      = ((DATA_WIDTH + CNT_W + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // command, operand_value, zero pad
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata,  // item_value, stack_count, zero pad
	output logic [ST_W:0]    m_tuser,  // has_value, status
	output logic             m_tlast   // last_of_run
);

	op_ctl_t               op;
	logic [DATA_WIDTH-1:0] op_value;
	logic                  op_ready;

	logic [DATA_WIDTH-1:0] res_value;
	logic                  res_has;
	status_t               res_status;
	logic                  res_last;
	logic [CNT_W-1:0]      res_count;

	// front end: decode and queue
	ose_front #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_cmd   (s_tdata[CMD_W-1:0]),
		.in_value (s_tdata[CMD_W+DATA_WIDTH-1:CMD_W]),
		.op       (op),
		.op_value (op_value),
		.op_ready (op_ready)
	);

	// back end: stack memory, top register, result register
	ose_back #(
		.STACK_DEPTH (STACK_DEPTH),
		.DATA_WIDTH  (DATA_WIDTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.op_value   (op_value),
		.op_ready   (op_ready),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res_value  (res_value),
		.res_has    (res_has),
		.res_status (res_status),
		.res_last   (res_last),
		.res_count  (res_count)
	);

	// pack output word, pad bits held at zero
	always_comb begin
		m_tdata = '0;
		m_tdata[DATA_WIDTH-1:0] = res_value;
		m_tdata[DATA_WIDTH+CNT_W-1:DATA_WIDTH] = res_count;
	end

	assign m_tuser = {res_status, res_has};
	assign m_tlast = res_last;

endmodule
